// File: rtl/lfpd_pkg.sv
`default_nettype none
package lfpd_pkg;

  localparam int unsigned SensorCount = 8;
  localparam int unsigned SelW = $clog2(SensorCount);
  localparam int unsigned BaseW = 15;
  localparam int unsigned GainW = 10;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivSteps = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_SPEED  = 2'd0,
    REG_PROP_GAIN   = 2'd1,
    REG_DERIV_GAIN  = 2'd2,
    REG_BRAKE_SPEED = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_D,
    ST_DONE
  } state_e;

  // -7, -5, ... 7 from left to right
  function automatic logic signed [3:0] pos_weight(input logic [SelW-1:0] idx);
    pos_weight = $signed({~idx[2], idx[1:0], 1'b1});
  endfunction

endpackage
`default_nettype wire

// File: rtl/lfpd_if.sv
`default_nettype none
interface lfpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_bits;
  modport source (output valid, output line_bits, input ready);
  modport sink (input valid, input line_bits, output ready);
endinterface

interface lfpd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lfpd_pkg::SpeedW-1:0]     left_drive;
  logic signed [lfpd_pkg::SpeedW-1:0]     right_drive;
  logic                                   line_lost;
  modport source (output valid, output left_drive, output right_drive,
                  output line_lost, input ready);
  modport sink (input valid, input left_drive, input right_drive,
                input line_lost, output ready);
endinterface
`default_nettype wire

// File: rtl/line_follow_pd_steering_unit.sv
`default_nettype none
// Channel    Dir  Payload                                   Handshake
// sample_i   in   line_bits[7:0]                            valid/ready
// result_o   out  left_drive[15:0] right_drive[15:0] lost   valid/ready
// cfg        in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[14:0] write only
//
// One sample passes from accept to result valid through a scan of the 8 sensors
// through the shared adder, 5 divide steps, the P and D multiplies on the
// shared multiplier and an output load; a lost line skips from scan to load.
// Ready is high only in idle; a pending result does not block the next sample,
// which waits in its final step until the result register is free.
// Async active-low reset clears control state, config registers, result valid and the kept error.
module line_follow_pd_steering_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  lfpd_in_if.sink                                sample_i,
  lfpd_out_if.source                             result_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lfpd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [lfpd_pkg::CfgDataW-1:0]     cfg_data_i
);

  lfpd_pkg::state_e state_q, state_d;

  logic [lfpd_pkg::BaseW-1:0] base_q, brake_q;
  logic [lfpd_pkg::GainW-1:0] kp_q, kd_q;

  logic [7:0]                  bits_q, bits_d;
  logic [lfpd_pkg::SelW-1:0]   idx_q, idx_d;
  logic signed [5:0]           sum_q, sum_d;
  logic [3:0]                  cnt_q, cnt_d;
  logic [4:0]                  mag_q, mag_d;
  logic [4:0]                  rem_q, rem_d;
  logic [4:0]                  quo_q, quo_d;
  logic                        neg_q, neg_d;
  logic [2:0]                  step_q, step_d;
  logic signed [3:0]           err_q, err_d;
  logic signed [3:0]           prev_q, prev_d;
  logic signed [16:0]          turn_q, turn_d;
  logic                        lost_q, lost_d;

  logic                        res_valid_q, res_valid_d;
  logic [lfpd_pkg::SpeedW-1:0] res_left_q, res_left_d, res_right_q, res_right_d;
  logic                        res_lost_q, res_lost_d;

  logic signed [5:0]           sum_abs;
  logic [4:0]                  div_t;
  logic signed [4:0]           derr;
  logic signed [10:0]          mul_a;
  logic signed [4:0]           mul_b;
  logic signed [15:0]          prod;
  logic [lfpd_pkg::SpeedW-1:0] base_ext;

  assign derr = 5'(err_q) - 5'(prev_q);
  assign mul_a = $signed({1'b0, (state_q == lfpd_pkg::ST_MUL_P) ? kp_q : kd_q});
  assign mul_b = (state_q == lfpd_pkg::ST_MUL_P) ? 5'(err_q) : derr;
  assign prod = 16'(mul_a * mul_b);
  assign div_t = {rem_q[3:0], mag_q[4]};
  assign base_ext = {1'b0, base_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      kp_q    <= '0;
      kd_q    <= '0;
      brake_q <= '0;
    end else if (cfg_we_i) begin
      unique case (lfpd_pkg::cfg_reg_e'(cfg_idx_i))
        lfpd_pkg::REG_BASE_SPEED:  base_q  <= cfg_data_i[lfpd_pkg::BaseW-1:0];
        lfpd_pkg::REG_PROP_GAIN:   kp_q    <= cfg_data_i[lfpd_pkg::GainW-1:0];
        lfpd_pkg::REG_DERIV_GAIN:  kd_q    <= cfg_data_i[lfpd_pkg::GainW-1:0];
        lfpd_pkg::REG_BRAKE_SPEED: brake_q <= cfg_data_i[lfpd_pkg::BaseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfpd_pkg::ST_IDLE;
      prev_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q      <= bits_d;
    idx_q       <= idx_d;
    sum_q       <= sum_d;
    cnt_q       <= cnt_d;
    mag_q       <= mag_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    neg_q       <= neg_d;
    step_q      <= step_d;
    err_q       <= err_d;
    turn_q      <= turn_d;
    lost_q      <= lost_d;
    res_left_q  <= res_left_d;
    res_right_q <= res_right_d;
    res_lost_q  <= res_lost_d;
  end

  always_comb begin
    state_d     = state_q;
    bits_d      = bits_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    step_d      = step_q;
    err_d       = err_q;
    prev_d      = prev_q;
    turn_d      = turn_q;
    lost_d      = lost_q;
    res_valid_d = res_valid_q && !result_o.ready;
    res_left_d  = res_left_q;
    res_right_d = res_right_q;
    res_lost_d  = res_lost_q;
    sum_abs     = '0;

    unique case (state_q)
      lfpd_pkg::ST_IDLE: begin
        if (sample_i.valid) begin
          bits_d  = sample_i.line_bits;
          idx_d   = '0;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = lfpd_pkg::ST_SCAN;
        end
      end
      lfpd_pkg::ST_SCAN: begin
        if (bits_q[idx_q]) begin
          sum_d = sum_q + 6'(lfpd_pkg::pos_weight(idx_q));
          cnt_d = cnt_q + 4'd1;
        end
        idx_d = idx_q + lfpd_pkg::SelW'(1);
        if (idx_q == lfpd_pkg::SelW'(lfpd_pkg::SensorCount - 1)) begin
          sum_abs = sum_d[5] ? -sum_d : sum_d;
          mag_d   = sum_abs[4:0];
          neg_d   = sum_d[5];
          rem_d   = '0;
          quo_d   = '0;
          step_d  = '0;
          lost_d  = (cnt_d == 4'd0);
          state_d = (cnt_d == 4'd0) ? lfpd_pkg::ST_DONE : lfpd_pkg::ST_DIV;
        end
      end
      lfpd_pkg::ST_DIV: begin
        mag_d = {mag_q[3:0], 1'b0};
        if (div_t >= {1'b0, cnt_q}) begin
          rem_d = div_t - {1'b0, cnt_q};
          quo_d = {quo_q[3:0], 1'b1};
        end else begin
          rem_d = div_t;
          quo_d = {quo_q[3:0], 1'b0};
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'(lfpd_pkg::DivSteps - 1)) begin
          err_d   = neg_q ? -$signed(quo_d[3:0]) : $signed(quo_d[3:0]);
          state_d = lfpd_pkg::ST_MUL_P;
        end
      end
      lfpd_pkg::ST_MUL_P: begin
        turn_d  = 17'(prod);
        state_d = lfpd_pkg::ST_MUL_D;
      end
      lfpd_pkg::ST_MUL_D: begin
        turn_d  = turn_q + 17'(prod);
        prev_d  = err_q;
        state_d = lfpd_pkg::ST_DONE;
      end
      lfpd_pkg::ST_DONE: begin
        if (!res_valid_q || result_o.ready) begin
          res_valid_d = 1'b1;
          res_lost_d  = lost_q;
          if (lost_q) begin
            res_left_d  = -{1'b0, brake_q};
            res_right_d = -{1'b0, brake_q};
          end else begin
            res_left_d  = base_ext + turn_q[15:0];
            res_right_d = base_ext - turn_q[15:0];
          end
          state_d = lfpd_pkg::ST_IDLE;
        end
      end
      default: state_d = lfpd_pkg::ST_IDLE;
    endcase
  end

  assign sample_i.ready       = (state_q == lfpd_pkg::ST_IDLE);
  assign result_o.valid       = res_valid_q;
  assign result_o.left_drive  = $signed(res_left_q);
  assign result_o.right_drive = $signed(res_right_q);
  assign result_o.line_lost   = res_lost_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("ready stayed high after a sample beat");

  a_lost_same_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.line_lost) |->
      (result_o.left_drive == result_o.right_drive))
    else $error("lost-line beat with unequal speeds");

  a_prev_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_q != 4'b1000)
    else $error("kept error out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfpd_pkg::ST_DIV) |-> (cnt_q != 4'd0 && cnt_q <= 4'd8))
    else $error("bad divisor in divide");

endmodule
`default_nettype wire
